// ===== design/erbn_pkg.sv =====
// Shared constants, types and tables of the ERB feature normaliser.
package erbn_pkg;

    localparam int NUM_BANDS     = 32;
    localparam int NUM_NORM_BINS = 96;
    localparam int NUM_BINS      = 481;

    // the width table has 32 entries, so no more bands than that are tracked
    localparam int BAND_LIM = (NUM_BANDS < 32) ? NUM_BANDS : 32;
    localparam int BIN_W    = $clog2(NUM_BINS + 1);
    localparam int BAND_W   = $clog2(BAND_LIM + 1);
    localparam int BAND_AW  = (BAND_LIM > 1) ? $clog2(BAND_LIM) : 1;
    localparam int NORM_AW  = (NUM_NORM_BINS > 1) ? $clog2(NUM_NORM_BINS) : 1;

    localparam logic [15:0] ALPHA_RESET = 16'd64881;
    localparam logic [47:0] EPS_Q44     = 48'd1759;
    localparam logic [23:0] LOG2_OFFSET = 24'd2883584;   // 44 in Q.16
    localparam logic [18:0] DB_PER_LOG2 = 19'd197283;    // 10*log10(2) in Q.16
    localparam logic [16:0] RECIP5      = 17'd52429;     // 2^18 / 5, rounded up

    localparam longint MAG_N1  = longint'(NUM_NORM_BINS) - 1;
    localparam longint MAG_DEN = (MAG_N1 > 0) ? 64'd1000000 * MAG_N1 : 64'd1;
    localparam longint BAND_DEN = (NUM_BANDS > 1) ? longint'(NUM_BANDS) - 1 : 64'd1;

    typedef struct packed {
        logic signed [23:0] bin_real;
        logic signed [23:0] bin_imag;
        logic               frame_start;
    } in_item_t;

    typedef struct packed {
        logic               feature_kind;
        logic [6:0]         feature_index;
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
        logic               frame_last;
    } out_item_t;

    // one classified bin, passed from the front to the back
    typedef struct packed {
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic [BIN_W-1:0]   k;
        logic [BAND_W-1:0]  band;
        logic [6:0]         width;
        logic               norm;
        logic               band_ok;
        logic               band_end;
        logic               sum_clr;
        logic               last;
    } desc_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ_RE, S_SQ_IM, S_MSQRT, S_MMUL1, S_MMUL2, S_SSQRT, S_NSET, S_NDIV,
        S_EMIT_N, S_ACC, S_BDIV, S_NORM, S_LOG, S_DB1, S_DB2, S_MEAN1, S_MEAN2,
        S_MEAN3, S_FEAT1, S_FEAT2, S_EMIT_B
    } back_state_t;

    function automatic logic [6:0] erb_width(input logic [4:0] i);
        logic [6:0] w;
        case (i)
            5'd13, 5'd14: w = 7'd5;
            5'd15, 5'd16: w = 7'd7;
            5'd17: w = 7'd8;
            5'd18: w = 7'd10;
            5'd19: w = 7'd12;
            5'd20: w = 7'd13;
            5'd21: w = 7'd15;
            5'd22: w = 7'd18;
            5'd23: w = 7'd20;
            5'd24: w = 7'd24;
            5'd25: w = 7'd28;
            5'd26: w = 7'd31;
            5'd27: w = 7'd37;
            5'd28: w = 7'd42;
            5'd29: w = 7'd50;
            5'd30: w = 7'd56;
            5'd31: w = 7'd67;
            default: w = 7'd2;
        endcase
        return w;
    endfunction

    function automatic logic [23:0] mag_init(input int f);
        longint num;
        if (MAG_N1 <= 0)
            return 24'd4194;
        num = 64'd4194304 * (64'd1000 * MAG_N1 - 64'd900 * longint'(f));
        return 24'((num + MAG_DEN / 2) / MAG_DEN);
    endfunction

    function automatic logic signed [15:0] band_init(input int b);
        longint off;
        off = (NUM_BANDS > 1) ? (64'd3840 * longint'(b) + BAND_DEN / 2) / BAND_DEN : 64'd0;
        return 16'(-64'd7680 - off);
    endfunction

endpackage

// ===== design/erbn_front.sv =====
// Front end: accepts bins, tracks frame and band position, classifies each bin.
module erbn_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  erbn_pkg::in_item_t in_data,
    output logic              push,
    output erbn_pkg::desc_t   push_data,
    input  logic              full
);
    import erbn_pkg::*;

    logic [BIN_W-1:0]  bin_cnt_reg, bin_cnt_next;
    logic [BAND_W-1:0] band_cnt_reg, band_cnt_next;
    logic [6:0]        band_pos_reg, band_pos_next;
    logic [BIN_W-1:0]  bc;
    logic [BAND_W-1:0] bd;
    logic [6:0]        bp;
    logic              take;
    logic              in_frame;

    assign in_stall = full;
    assign take     = in_valid && !full;

    always_comb
    begin
        bc = in_data.frame_start ? '0 : bin_cnt_reg;
        bd = in_data.frame_start ? '0 : band_cnt_reg;
        bp = in_data.frame_start ? '0 : band_pos_reg;
        in_frame = (32'(bc) < NUM_BINS);

        push_data.re       = in_data.bin_real;
        push_data.im       = in_data.bin_imag;
        push_data.k        = bc;
        push_data.band     = bd;
        push_data.width    = erb_width(5'(bd));
        push_data.norm     = (32'(bc) < NUM_NORM_BINS);
        push_data.band_ok  = (32'(bd) < BAND_LIM);
        push_data.band_end = push_data.band_ok && ((bp + 7'd1) >= push_data.width);
        push_data.sum_clr  = (bp == '0);
        push_data.last     = (32'(bc) == NUM_BINS - 1);

        push          = take && in_frame;
        bin_cnt_next  = bin_cnt_reg;
        band_cnt_next = band_cnt_reg;
        band_pos_next = band_pos_reg;
        if (push)
        begin
            bin_cnt_next  = bc + 1'b1;
            band_cnt_next = bd;
            band_pos_next = bp;
            if (push_data.band_ok)
            begin
                if (push_data.band_end)
                begin
                    band_cnt_next = bd + 1'b1;
                    band_pos_next = '0;
                end
                else
                begin
                    band_pos_next = bp + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_cnt_reg  <= '0;
            band_cnt_reg <= '0;
            band_pos_reg <= '0;
        end
        else
        begin
            bin_cnt_reg  <= bin_cnt_next;
            band_cnt_reg <= band_cnt_next;
            band_pos_reg <= band_pos_next;
        end
    end

endmodule

// ===== design/erbn_queue.sv =====
// Two-entry queue of classified bins between front and back.
module erbn_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  erbn_pkg::desc_t push_data,
    output logic            full,
    input  logic            pop,
    output erbn_pkg::desc_t pop_data,
    output logic            empty
);
    import erbn_pkg::*;

    desc_t      slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== design/erbn_back.sv =====
// Back end: power, square roots, divisions, log and running means; holds the result register.
module erbn_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        alpha,
    input  logic               empty,
    input  erbn_pkg::desc_t    q_data,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output erbn_pkg::out_item_t out_data
);
    import erbn_pkg::*;

    back_state_t state_reg, state_next;

    desc_t               desc_reg;
    logic [47:0]         prod_reg, pw_reg, sum_reg;
    logic [55:0]         sx_reg;
    logic [29:0]         srem_reg;
    logic [27:0]         sroot_reg, s_reg;
    logic [47:0]         dq_reg;
    logic [27:0]         dden_reg, drem_reg;
    logic [5:0]          cnt_reg;
    logic [40:0]         mp_reg;
    logic                part_sel_reg;
    logic signed [15:0]  val_a_reg, val_b_reg;
    logic [63:0]         lz_reg;
    logic [5:0]          e_reg;
    logic [31:0]         m_reg;
    logic [15:0]         frac_reg;
    logic signed [42:0]  db_prod_reg;
    logic signed [17:0]  db_reg;
    logic signed [39:0]  mean_reg;
    logic signed [15:0]  mnew_reg;
    logic [37:0]         fprod_reg;
    logic                fneg_reg;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic [23:0]         mag_mem [NUM_NORM_BINS];
    logic                mag_vld_reg [NUM_NORM_BINS];
    logic [23:0]         mag_init_tab [NUM_NORM_BINS];
    logic [23:0]         mag_rd_reg;
    logic                mag_vld_rd_reg;
    logic signed [15:0]  band_db_reg [BAND_LIM];

    // combinational helpers
    logic signed [47:0]  sq_re, sq_im;
    logic [47:0]         pw_sum;
    logic [31:0]         sq_r, sq_trial;
    logic                sq_ge;
    logic [29:0]         srem_n;
    logic [27:0]         sroot_n;
    logic [28:0]         dr;
    logic                dge;
    logic [27:0]         drem_n;
    logic [47:0]         dq_n;
    logic [63:0]         lp;
    logic [32:0]         lt;
    logic [16:0]         na;
    logic [NORM_AW-1:0]  k_idx;
    logic [BAND_AW-1:0]  b_idx;
    logic [23:0]         old_mag;
    logic signed [15:0]  old_db;
    logic [40:0]         mmul;
    logic [41:0]         msum;
    logic signed [23:0]  part;
    logic [23:0]         part_mag;
    logic signed [23:0]  tdb;
    logic signed [42:0]  db_mul;
    logic [42:0]         db_mag;
    logic [17:0]         db_q;
    logic signed [39:0]  mean_p1, mean_p2;
    logic [39:0]         mean_mag;
    logic [23:0]         mean_q;
    logic signed [24:0]  mean_r;
    logic signed [18:0]  fd;
    logic [18:0]         fd_mag;
    logic [20:0]         fx;
    logic [48:0]         acc_tot;
    logic [47:0]         acc_sat;
    logic [48:0]         bx;
    logic                slot_free;
    logic                out_load;

    function automatic logic signed [15:0] sat_q(input logic [47:0] q, input logic neg);
        if (neg)
            return (q > 48'd32768) ? -16'sd32768 : 16'(-q);
        else
            return (q > 48'd32767) ? 16'sd32767 : 16'(q);
    endfunction

    function automatic logic signed [15:0] sign_sat(input logic signed [23:0] p);
        if (p > 0)
            return 16'sd32767;
        else if (p < 0)
            return -16'sd32768;
        else
            return 16'sd0;
    endfunction

    for (genvar g = 0; g < NUM_NORM_BINS; g++)
    begin : g_init
        assign mag_init_tab[g] = mag_init(g);
    end

    always_comb
    begin
        sq_re  = desc_reg.re * desc_reg.re;
        sq_im  = desc_reg.im * desc_reg.im;
        pw_sum = prod_reg + 48'(sq_im);

        sq_r     = {srem_reg, sx_reg[55:54]};
        sq_trial = {2'b00, sroot_reg, 2'b01};
        sq_ge    = (sq_r >= sq_trial);
        srem_n   = sq_ge ? 30'(sq_r - sq_trial) : 30'(sq_r);
        sroot_n  = {sroot_reg[26:0], sq_ge};

        dr     = {drem_reg, dq_reg[47]};
        dge    = (dr >= {1'b0, dden_reg});
        drem_n = dge ? 28'(dr - {1'b0, dden_reg}) : dr[27:0];
        dq_n   = {dq_reg[46:0], dge};

        lp = m_reg * m_reg;
        lt = lp[63:31];

        na      = 17'd65536 - {1'b0, alpha};
        k_idx   = desc_reg.k[NORM_AW-1:0];
        b_idx   = desc_reg.band[BAND_AW-1:0];
        old_mag = mag_vld_rd_reg ? mag_rd_reg : mag_init_tab[k_idx];
        old_db  = band_db_reg[b_idx];
        mmul    = 41'(sroot_reg[23:0]) * 41'(na);
        msum    = 42'(mp_reg) + 42'(old_mag) * 42'(alpha) + 42'd32768;

        part     = part_sel_reg ? desc_reg.im : desc_reg.re;
        part_mag = part[23] ? 24'(-part) : 24'(part);

        tdb    = $signed({2'b00, e_reg, frac_reg}) - $signed(LOG2_OFFSET);
        db_mul = tdb * $signed({1'b0, DB_PER_LOG2});
        db_mag = db_prod_reg[42] ? 43'(-db_prod_reg) : 43'(db_prod_reg);
        db_q   = 18'((db_mag + 43'd16777216) >> 25);

        mean_p1  = db_reg * $signed({1'b0, na});
        mean_p2  = mean_reg + old_db * $signed({1'b0, alpha});
        mean_mag = mean_reg[39] ? 40'(-mean_reg) : 40'(mean_reg);
        mean_q   = 24'((mean_mag + 40'd32768) >> 16);
        mean_r   = mean_reg[39] ? -$signed({1'b0, mean_q}) : $signed({1'b0, mean_q});

        fd     = db_reg - mnew_reg;
        fd_mag = fd[18] ? 19'(-fd) : 19'(fd);
        fx     = {fd_mag[18:0], 2'b00} + 21'd2;

        acc_tot = 49'(desc_reg.sum_clr ? 48'd0 : sum_reg) + 49'(pw_reg);
        acc_sat = acc_tot[48] ? '1 : acc_tot[47:0];
        bx      = 49'(dq_n) + 49'(EPS_Q44);

        slot_free = !out_valid_reg || !out_stall;
    end

    // next state and handshake controls
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = S_SQ_RE;
                end
            end
            S_SQ_RE: state_next = S_SQ_IM;
            S_SQ_IM:
            begin
                if (desc_reg.norm)
                    state_next = S_MSQRT;
                else if (desc_reg.band_ok)
                    state_next = S_ACC;
                else
                    state_next = S_IDLE;
            end
            S_MSQRT: if (cnt_reg == 6'd27) state_next = S_MMUL1;
            S_MMUL1: state_next = S_MMUL2;
            S_MMUL2: state_next = S_SSQRT;
            S_SSQRT: if (cnt_reg == 6'd27) state_next = S_NSET;
            S_NSET:  state_next = (s_reg == '0) ? S_EMIT_N : S_NDIV;
            S_NDIV:
            begin
                if (cnt_reg == 6'd47)
                    state_next = part_sel_reg ? S_EMIT_N : S_NSET;
            end
            S_EMIT_N:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = desc_reg.band_ok ? S_ACC : S_IDLE;
                end
            end
            S_ACC:   state_next = desc_reg.band_end ? S_BDIV : S_IDLE;
            S_BDIV:  if (cnt_reg == 6'd47) state_next = S_NORM;
            S_NORM:  if (lz_reg[63]) state_next = S_LOG;
            S_LOG:   if (cnt_reg == 6'd15) state_next = S_DB1;
            S_DB1:   state_next = S_DB2;
            S_DB2:   state_next = S_MEAN1;
            S_MEAN1: state_next = S_MEAN2;
            S_MEAN2: state_next = S_MEAN3;
            S_MEAN3: state_next = S_FEAT1;
            S_FEAT1: state_next = S_FEAT2;
            S_FEAT2: state_next = S_EMIT_B;
            S_EMIT_B:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cnt_reg <= (state_next != state_reg) ? 6'd0 : cnt_reg + 6'd1;
        case (state_reg)
            S_IDLE:  if (!empty) desc_reg <= q_data;
            S_SQ_RE: prod_reg <= 48'(sq_re);
            S_SQ_IM:
            begin
                pw_reg    <= pw_sum;
                sx_reg    <= {8'd0, pw_sum};
                srem_reg  <= '0;
                sroot_reg <= '0;
            end
            S_MSQRT, S_SSQRT:
            begin
                srem_reg  <= srem_n;
                sroot_reg <= sroot_n;
                sx_reg    <= {sx_reg[53:0], 2'b00};
                if (state_reg == S_SSQRT)
                    s_reg <= sroot_n;
            end
            S_MMUL1:
            begin
                mp_reg       <= mmul;
                part_sel_reg <= 1'b0;
            end
            S_MMUL2:
            begin
                sx_reg    <= {msum[39:16], 32'd0};
                srem_reg  <= '0;
                sroot_reg <= '0;
            end
            S_NSET:
            begin
                if (s_reg == '0)
                begin
                    val_a_reg <= sign_sat(desc_reg.re);
                    val_b_reg <= sign_sat(desc_reg.im);
                end
                dq_reg   <= 48'({part_mag, 17'd0}) + 48'(s_reg >> 1);
                dden_reg <= s_reg;
                drem_reg <= '0;
            end
            S_NDIV, S_BDIV:
            begin
                dq_reg   <= dq_n;
                drem_reg <= drem_n;
                if (state_reg == S_NDIV && cnt_reg == 6'd47)
                begin
                    if (part_sel_reg)
                        val_b_reg <= sat_q(dq_n, part[23]);
                    else
                        val_a_reg <= sat_q(dq_n, part[23]);
                    part_sel_reg <= 1'b1;
                end
                lz_reg <= 64'(bx);
                e_reg  <= 6'd63;
            end
            S_ACC:
            begin
                sum_reg  <= acc_sat;
                dq_reg   <= acc_sat;
                dden_reg <= 28'(desc_reg.width);
                drem_reg <= '0;
            end
            S_NORM:
            begin
                if (!lz_reg[63])
                begin
                    lz_reg <= {lz_reg[62:0], 1'b0};
                    e_reg  <= e_reg - 6'd1;
                end
                m_reg    <= lz_reg[63:32];
                frac_reg <= '0;
            end
            S_LOG:
            begin
                m_reg    <= lt[32] ? lt[32:1] : lt[31:0];
                frac_reg <= {frac_reg[14:0], lt[32]};
            end
            S_DB1:   db_prod_reg <= db_mul;
            S_DB2:   db_reg <= db_prod_reg[42] ? -$signed(db_q) : $signed(db_q);
            S_MEAN1: mean_reg <= mean_p1;
            S_MEAN2: mean_reg <= mean_p2;
            S_MEAN3:
            begin
                if (mean_r > 25'sd32767)
                    mnew_reg <= 16'sd32767;
                else if (mean_r < -25'sd32768)
                    mnew_reg <= -16'sd32768;
                else
                    mnew_reg <= 16'(mean_r);
            end
            S_FEAT1:
            begin
                fprod_reg <= 38'(fx) * 38'(RECIP5);
                fneg_reg  <= fd[18];
            end
            S_FEAT2: val_a_reg <= sat_q(48'(fprod_reg[37:18]), fneg_reg);
            default: ;
        endcase

        if (out_load)
        begin
            if (state_reg == S_EMIT_N)
            begin
                out_data_reg.feature_kind  <= 1'b0;
                out_data_reg.feature_index <= 7'(desc_reg.k);
                out_data_reg.value_a       <= val_a_reg;
                out_data_reg.value_b       <= val_b_reg;
                out_data_reg.frame_last    <= desc_reg.last &&
                                              !(desc_reg.band_ok && desc_reg.band_end);
            end
            else
            begin
                out_data_reg.feature_kind  <= 1'b1;
                out_data_reg.feature_index <= 7'(desc_reg.band);
                out_data_reg.value_a       <= val_a_reg;
                out_data_reg.value_b       <= 16'sd0;
                out_data_reg.frame_last    <= desc_reg.last;
            end
        end
    end

    // running magnitude memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MMUL2)
            mag_mem[k_idx] <= msum[39:16];
        if (state_reg == S_SQ_IM)
            mag_rd_reg <= mag_mem[k_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_NORM_BINS; i++)
                mag_vld_reg[i] <= 1'b0;
            mag_vld_rd_reg <= 1'b0;
            for (int i = 0; i < BAND_LIM; i++)
                band_db_reg[i] <= band_init(i);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_MMUL2)
                mag_vld_reg[k_idx] <= 1'b1;
            if (state_reg == S_SQ_IM)
                mag_vld_rd_reg <= mag_vld_reg[k_idx];
            if (state_reg == S_MEAN3)
            begin
                if (mean_r > 25'sd32767)
                    band_db_reg[b_idx] <= 16'sd32767;
                else if (mean_r < -25'sd32768)
                    band_db_reg[b_idx] <= -16'sd32768;
                else
                    band_db_reg[b_idx] <= 16'(mean_r);
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/erb_feature_normalizer.sv =====
// ERB band log-power features and unit-norm bin normaliser, top level.
//
// Input channel (in_valid / in_stall / in_data): one complex spectrum bin per
// transfer, Q1.22, with frame_start marking bin zero of a frame.
// Output channel (out_valid / out_stall / out_data): zero, one or two results
// per bin; a normalised bin (kind 0) comes before a band feature (kind 1).
// cfg_write / cfg_data load the 16-bit smoothing factor, Q0.16.
//
// In the back end every bin has its power formed; a normalised bin also takes two
// 28-step square roots and two 48-step divisions in the shared units, and the last
// bin of a band a 48-step division, a normalising shift and 16 squaring steps of
// the log. Bins past the frame end never reach the back end.
// The back end handles one bin at a time; a two-entry queue lets the front
// take bins while it works, so in_stall rises only when the queue is full.
// Results leave through one output register; a stalled receiver holds it and
// the back end waits, then the queue fills, then in_stall rises.
// Reset clears counters and the queue, restores the default factor and the
// initial running means at once; no clearing pass is needed.
module erb_feature_normalizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  erbn_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output erbn_pkg::out_item_t out_data,
    input  logic                cfg_write,
    input  logic [15:0]         cfg_data
);
    import erbn_pkg::*;

    logic [15:0] alpha_q_reg;
    logic        push, full, pop, empty;
    desc_t       push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_q_reg <= ALPHA_RESET;
        end
        else if (cfg_write)
        begin
            alpha_q_reg <= cfg_data;
        end
    end

    erbn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    erbn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    erbn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .alpha     (alpha_q_reg),
        .empty     (empty),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
